// ----- rtl/crossover_genotype_lookup_core_assert.svh -----
// Assertion macros for the genotype lookup core
`ifndef CROSSOVER_GENOTYPE_LOOKUP_CORE_ASSERT_SVH
`define CROSSOVER_GENOTYPE_LOOKUP_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CGL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define CGL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cgl_pkg.sv -----
package cgl_pkg;

   // Field widths
   localparam int POS_W    = 32;
   localparam int ALLELE_W = 4;
   localparam int GENO_W   = 9;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 1 << ALLELE_W;

   // Defaults and fixed limits
   localparam int MAX_SEGMENTS_DEFAULT = 32;
   localparam int FOUNDER_COUNT        = 8;

   // Request kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_LOAD_MAT = 2'd0,
      REQ_LOAD_PAT = 2'd1,
      REQ_QUERY    = 2'd2,
      REQ_CLEAR    = 2'd3
   } cgl_req_type;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   // Register map (word index)
   localparam logic REG_MULTI_FOUNDER_MODE = 1'b0;

   // Query token walking down the row of cells
   typedef struct packed {
      logic                active;
      logic [POS_W-1:0]    pos;
      logic [ALLELE_W-1:0] mat;
      logic [ALLELE_W-1:0] pat;
   } cgl_token_type;

   // Segment write broadcast to every cell
   typedef struct packed {
      logic                mat_we;
      logic                pat_we;
      logic [POS_W-1:0]    seg_end;
      logic [ALLELE_W-1:0] founder;
   } cgl_load_type;

endpackage

// ----- rtl/cgl_cell.sv -----
module cgl_cell #(
   parameter int MAX_SEGMENTS = cgl_pkg::MAX_SEGMENTS_DEFAULT,
   parameter int INDEX        = 0,
   localparam int CNT_W       = $clog2(MAX_SEGMENTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cgl_pkg::cgl_load_type load,
   input  logic [CNT_W-1:0]      mat_count,
   input  logic [CNT_W-1:0]      pat_count,
   input  cgl_pkg::cgl_token_type tok_left,
   output cgl_pkg::cgl_token_type tok_right
);

   logic [cgl_pkg::POS_W-1:0]    mat_end_ff;
   logic [cgl_pkg::ALLELE_W-1:0] mat_fdr_ff;
   logic [cgl_pkg::POS_W-1:0]    pat_end_ff;
   logic [cgl_pkg::ALLELE_W-1:0] pat_fdr_ff;
   cgl_pkg::cgl_token_type       tok_ff;
   cgl_pkg::cgl_token_type       tok_in;
   logic                         mat_hit;
   logic                         pat_hit;

   // Segment storage: this cell holds entry INDEX of each list
   always_ff @(posedge clock) begin
      if (load.mat_we && (mat_count == CNT_W'(INDEX))) begin
         mat_end_ff <= load.seg_end;
         mat_fdr_ff <= load.founder;
      end
      if (load.pat_we && (pat_count == CNT_W'(INDEX))) begin
         pat_end_ff <= load.seg_end;
         pat_fdr_ff <= load.founder;
      end
   end

   // First reaching segment wins: only fill an allele still empty
   always_comb begin
      mat_hit = (tok_left.mat == '0) && (CNT_W'(INDEX) < mat_count) &&
                (mat_end_ff >= tok_left.pos);
      pat_hit = (tok_left.pat == '0) && (CNT_W'(INDEX) < pat_count) &&
                (pat_end_ff >= tok_left.pos);
      tok_in     = tok_left;
      if (mat_hit) begin
         tok_in.mat = mat_fdr_ff;
      end
      if (pat_hit) begin
         tok_in.pat = pat_fdr_ff;
      end
   end

   // Hand the token on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else if (advance) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_right = tok_ff;

endmodule

// ----- rtl/crossover_genotype_lookup_core.sv -----
// Loads and clears: one transaction per cycle while no query is in flight,
// taken in the cycle they arrive. Query: the token is registered at the head
// of the row and walks it one cell per cycle unless the result register is
// stalled; the next transaction is taken once the result is registered.
// Reset (synchronous, active high) empties both lists, clears the overflow
// flag, selects two-founder mode and drops any query in flight.
module crossover_genotype_lookup_core #(
   parameter int MAX_SEGMENTS = cgl_pkg::MAX_SEGMENTS_DEFAULT,
   localparam int CNT_W       = $clog2(MAX_SEGMENTS + 1)
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] position, [35:32] allele, [39:36] zero
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [8:0] genotype, [12:9] maternal_allele, [16:13] paternal_allele,
   // [18:17] status, [23:19] zero
   output logic [23:0] rsp_tdata,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int POS_W    = cgl_pkg::POS_W;
   localparam int ALLELE_W = cgl_pkg::ALLELE_W;
   localparam int GENO_W   = cgl_pkg::GENO_W;
   localparam int STATUS_W = cgl_pkg::STATUS_W;
   localparam int MASK_W   = cgl_pkg::MASK_W;

   logic                   mode_ff;
   logic [CNT_W-1:0]       mat_count_ff, mat_count_in;
   logic [CNT_W-1:0]       pat_count_ff, pat_count_in;
   logic                   ovf_ff, ovf_in;
   logic                   busy_ff, busy_in;
   cgl_pkg::cgl_token_type head_ff, head_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GENO_W-1:0]      geno_ff, geno_in;
   logic [ALLELE_W-1:0]    rsp_mat_ff, rsp_pat_ff;
   logic [STATUS_W-1:0]    status_ff, status_in;

   cgl_pkg::cgl_req_type   req_kind;
   logic [POS_W-1:0]       req_pos;
   logic [ALLELE_W-1:0]    req_allele;
   logic                   req_accept;
   logic                   allele_ok;
   logic                   mat_full, pat_full;
   cgl_pkg::cgl_load_type  load;
   logic                   advance;
   logic                   tail_take;
   cgl_pkg::cgl_token_type tail;
   cgl_pkg::cgl_token_type tok_chain [0:MAX_SEGMENTS];
   logic [MASK_W-1:0]      mask_mat, mask_pat;
   logic [MASK_W:0]        mask_sum;
   logic                   csr_write;
   logic                   csr_word;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_word == cgl_pkg::REG_MULTI_FOUNDER_MODE) ?
                       {31'd0, mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_write && (csr_word == cgl_pkg::REG_MULTI_FOUNDER_MODE)) begin
         mode_ff <= csr_pwdata[0];
      end
   end

   // ---------------- request decode ----------------
   assign req_kind   = cgl_pkg::cgl_req_type'(req_tuser);
   assign req_pos    = req_tdata[31:0];
   assign req_allele = req_tdata[35:32];
   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign allele_ok  = (req_allele != '0) &&
                       ({1'b0, req_allele} <= (ALLELE_W + 1)'(cgl_pkg::FOUNDER_COUNT));
   assign mat_full   = (mat_count_ff == CNT_W'(MAX_SEGMENTS));
   assign pat_full   = (pat_count_ff == CNT_W'(MAX_SEGMENTS));

   // List fill counts and overflow flag
   always_comb begin
      mat_count_in   = mat_count_ff;
      pat_count_in   = pat_count_ff;
      ovf_in         = ovf_ff;
      load.mat_we    = 1'b0;
      load.pat_we    = 1'b0;
      load.seg_end   = req_pos;
      load.founder   = req_allele;
      if (req_accept) begin
         unique case (req_kind)
            cgl_pkg::REQ_LOAD_MAT: begin
               if (allele_ok && mat_full) begin
                  ovf_in = 1'b1;
               end else if (allele_ok) begin
                  load.mat_we  = 1'b1;
                  mat_count_in = mat_count_ff + CNT_W'(1);
               end
            end
            cgl_pkg::REQ_LOAD_PAT: begin
               if (allele_ok && pat_full) begin
                  ovf_in = 1'b1;
               end else if (allele_ok) begin
                  load.pat_we  = 1'b1;
                  pat_count_in = pat_count_ff + CNT_W'(1);
               end
            end
            cgl_pkg::REQ_CLEAR: begin
               mat_count_in = '0;
               pat_count_in = '0;
               ovf_in       = 1'b0;
            end
            cgl_pkg::REQ_QUERY: begin
               ovf_in = ovf_ff;
            end
            default: begin
               ovf_in = ovf_ff;
            end
         endcase
      end
   end

   // ---------------- query token and the row of cells ----------------
   assign tail      = tok_chain[MAX_SEGMENTS];
   assign advance   = !(tail.active && rsp_valid_ff && !rsp_tready);
   assign tail_take = tail.active && advance;

   always_comb begin
      head_in.active = req_accept && (req_kind == cgl_pkg::REQ_QUERY);
      head_in.pos    = req_pos;
      head_in.mat    = '0;
      head_in.pat    = '0;
   end

   // One query in flight at a time
   always_comb begin
      priority if (head_in.active) begin
         busy_in = 1'b1;
      end else if (tail_take) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   assign tok_chain[0] = head_ff;

   for (genvar gi = 0; gi < MAX_SEGMENTS; gi++) begin : g_cell
      cgl_cell #(
         .MAX_SEGMENTS (MAX_SEGMENTS),
         .INDEX        (gi)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .load      (load),
         .mat_count (mat_count_ff),
         .pat_count (pat_count_ff),
         .tok_left  (tok_chain[gi]),
         .tok_right (tok_chain[gi+1])
      );
   end

   // ---------------- genotype combine ----------------
   assign mask_mat = MASK_W'(1) << (tail.mat - ALLELE_W'(1));
   assign mask_pat = MASK_W'(1) << (tail.pat - ALLELE_W'(1));
   assign mask_sum = {1'b0, mask_mat} + {1'b0, mask_pat};

   always_comb begin
      if ((tail.mat == '0) || (tail.pat == '0)) begin
         geno_in   = '0;
         status_in = cgl_pkg::STATUS_NOT_FOUND;
      end else if (mode_ff) begin
         geno_in   = mask_sum[GENO_W-1:0];
         status_in = cgl_pkg::STATUS_OK;
      end else begin
         geno_in   = GENO_W'(tail.mat) + GENO_W'(tail.pat) - GENO_W'(1);
         status_in = cgl_pkg::STATUS_OK;
      end
      if (ovf_ff) begin
         status_in = cgl_pkg::STATUS_OVERFLOW;
      end
   end

   // Output register
   always_comb begin
      priority if (tail_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mat_count_ff   <= '0;
         pat_count_ff   <= '0;
         ovf_ff         <= 1'b0;
         busy_ff        <= 1'b0;
         head_ff.active <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mat_count_ff <= mat_count_in;
         pat_count_ff <= pat_count_in;
         ovf_ff       <= ovf_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            head_ff <= head_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (tail_take) begin
         geno_ff    <= geno_in;
         rsp_mat_ff <= tail.mat;
         rsp_pat_ff <= tail.pat;
         status_ff  <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, status_ff, rsp_pat_ff, rsp_mat_ff, geno_ff};

   // ---------------- assertions ----------------
`include "crossover_genotype_lookup_core_assert.svh"

   `CGL_ASSERT_IMP(a_no_accept_busy, clock, reset, busy_ff, !req_tready, "transaction accepted with a query in flight")
   `CGL_ASSERT_NXT(a_query_busy, clock, reset, head_in.active, busy_ff, "query accepted but block not busy")
   `CGL_ASSERT_NXT(a_tail_to_rsp, clock, reset, tail_take, rsp_valid_ff, "token left the row without a result")
   `CGL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, (mat_count_ff <= CNT_W'(MAX_SEGMENTS)) && (pat_count_ff <= CNT_W'(MAX_SEGMENTS)), "list fill count beyond capacity")

endmodule
